[sv/heat_stencil_rk4_step_core_macros.svh]
// ----------------------------------------------------------------------------
// heat stencil rk4 step assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef HEAT_STENCIL_RK4_STEP_CORE_MACROS_SVH
`define HEAT_STENCIL_RK4_STEP_CORE_MACROS_SVH

// same-cycle implication
`define HSRK4_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsrk4 check failed");

// next-cycle implication
`define HSRK4_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsrk4 check failed");

`endif

[sv/hsrk4_pkg.sv]
// ----------------------------------------------------------------------------
// hsrk4_pkg
// types, codes and arithmetic helpers of the rk4 heat stencil core
// ----------------------------------------------------------------------------
package hsrk4_pkg;

  localparam int MAX_ROWS  = 128;
  localparam int MAX_COLS  = 128;
  localparam int FRAC_BITS = 16;
  localparam int ROW_W     = 7;
  localparam int COL_W     = 7;
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int CELLS     = MAX_ROWS * MAX_COLS;
  localparam int DATA_W    = 32;
  localparam int SUM_W     = 40;
  localparam int CMD_W     = 2;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_X = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_Y = 2'd3;

  typedef logic signed [DATA_W-1:0] temp_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic  border;
    temp_t t_data;
    temp_t g_data;
  } tap_t;

  localparam sum_t T_MAX = 40'sh00_7FFF_FFFF;
  localparam sum_t T_MIN = 40'shFF_8000_0000;

  function automatic temp_t sat32(input sum_t x);
    temp_t r;
    if (x > T_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < T_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/hsrk4_if.sv]
// ----------------------------------------------------------------------------
// hsrk4 channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface hsrk4_req_if;
  import hsrk4_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic signed [31:0]  value;
  modport source(output valid, cmd, row, col, value, input ready);
  modport sink(input valid, cmd, row, col, value, output ready);
endinterface

interface hsrk4_rsp_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  read_value;
  logic                status;
  modport source(output valid, read_value, status, input ready);
  modport sink(input valid, read_value, status, output ready);
endinterface

[sv/heat_stencil_rk4_step_core.sv]
// ----------------------------------------------------------------------------
// heat_stencil_rk4_step_core
// Grid of signed Q16.16 temperatures with cell write, cell read and one
// classical RK4 step of the 2D heat equation per advance item. A write or an
// unknown command goes straight to its result; a read first waits for the
// registered read data. An advance sweeps the interior four times, one cell
// at a time; an advance on a grid with no interior answers without a sweep.
// The pace per cell is set by the single read port of each grid memory (five
// stencil fetches per cell) and by the reciprocal divide by three of the
// final update. Border cells are read from the temperature grid and an
// advance never changes them. Items are taken one at a time.
// ----------------------------------------------------------------------------
`include "heat_stencil_rk4_step_core_macros.svh"

module heat_stencil_rk4_step_core (
  input  logic                            clk,
  input  logic                            rst,
  hsrk4_req_if.sink                       req,
  hsrk4_rsp_if.source                     rsp,
  input  logic                            cfg_we,
  input  logic [hsrk4_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [hsrk4_pkg::CFG_W-1:0]     cfg_data
);
  import hsrk4_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_FIN   = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DWR   = 3'd5;

  localparam int NTAP = 5;
  localparam int DIV_W = 34;

  // 2^17 = 3 * 43690 + 2, and ceil(2^20 / 3) for the low part
  localparam logic [32:0] HI_MUL = 33'd43690;
  localparam logic [37:0] LO_MUL = 38'd349526;

  logic [2:0] state;

  // configuration
  logic [7:0]  rows_in_use;
  logic [7:0]  cols_in_use;
  logic [15:0] gain_x;
  logic [15:0] gain_y;
  logic [7:0]  nr;
  logic [7:0]  nc;

  // sweep position
  logic [1:0]       stage;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;
  logic [3:0]       phase;
  logic             dcnt;

  // result slot
  logic        out_valid;
  temp_t       out_value;
  logic        out_status;
  temp_t       res_value;
  logic        res_status;
  logic        rd_ok;

  // memories
  logic              t_we;
  logic [ADDR_W-1:0] t_waddr;
  temp_t             t_wdata;
  logic [ADDR_W-1:0] rd_addr;
  temp_t             t_rd;
  temp_t             a_rd;
  temp_t             b_rd;
  logic [SUM_W-1:0]  s_rd;
  logic              a_we;
  logic              b_we;
  logic              s_we;
  logic [ADDR_W-1:0] k_addr;

  // window chain
  logic  rd_shift;
  logic  rd_border;
  logic  tap_shift;
  logic  tap_border;
  temp_t g_rd;
  tap_t  taps [NTAP+1];
  temp_t vals [NTAP];

  // datapath registers
  temp_t              u;
  sum_t               s;
  logic signed [33:0] sx;
  logic signed [33:0] sy;
  logic signed [50:0] px;
  logic signed [50:0] py;
  temp_t              d;
  logic [DIV_W-1:0]   dvd;
  logic [DIV_W-1:0]   qh;
  logic [18:0]        rsum;

  // combinational datapath
  logic signed [51:0] acc;
  logic signed [32:0] d1;
  temp_t              half;
  temp_t              a_val;
  sum_t               s_base;
  sum_t               s_inc;
  sum_t               s_new;
  sum_t               x3;
  sum_t               y3;
  sum_t               m40;
  logic [32:0]        qh_prod;
  logic [37:0]        rprod;
  logic signed [34:0] q;
  temp_t              t_new;

  logic accept;
  logic in_rng;
  logic last_col;
  logic last_row;

  assign nr = (rows_in_use > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : rows_in_use;
  assign nc = (cols_in_use > 8'(MAX_COLS)) ? 8'(MAX_COLS) : cols_in_use;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_rng    = ({1'b0, req.row} < nr) && ({1'b0, req.col} < nc);

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;

  assign k_addr   = {r, c};
  assign last_col = (({1'b0, c} + 8'd2) == nc);
  assign last_row = (({1'b0, r} + 8'd2) == nr);

  // read address and border flag of the fetch in progress
  always_comb begin
    rd_addr   = k_addr;
    rd_border = 1'b0;
    if (state == ST_IDLE) begin
      rd_addr = {req.row, req.col};
    end else begin
      case (phase)
        4'd0: begin
          rd_addr   = {r - ROW_W'(1), c};
          rd_border = (r == ROW_W'(1));
        end
        4'd1: begin
          rd_addr   = {r + ROW_W'(1), c};
          rd_border = last_row;
        end
        4'd2: begin
          rd_addr   = {r, c - COL_W'(1)};
          rd_border = (c == COL_W'(1));
        end
        4'd3: begin
          rd_addr   = {r, c + COL_W'(1)};
          rd_border = last_col;
        end
        default: begin
          rd_addr   = k_addr;
          rd_border = 1'b0;
        end
      endcase
    end
  end

  assign rd_shift = (state == ST_SWEEP) && (phase <= 4'd4);

  hsrk4_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_t_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(rd_addr), .rdata(t_rd)
  );
  hsrk4_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(k_addr), .wdata(a_val),
    .raddr(rd_addr), .rdata(a_rd)
  );
  hsrk4_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(k_addr), .wdata(a_val),
    .raddr(rd_addr), .rdata(b_rd)
  );
  hsrk4_ram #(.WIDTH(SUM_W), .DEPTH(CELLS)) u_s_ram (
    .clk(clk), .we(s_we), .waddr(k_addr), .wdata(s_new),
    .raddr(rd_addr), .rdata(s_rd)
  );

  // stage source grid
  always_comb begin
    case (stage)
      2'd0:    g_rd = t_rd;
      2'd2:    g_rd = b_rd;
      default: g_rd = a_rd;
    endcase
  end

  assign taps[0] = '{border: tap_border, t_data: t_rd, g_data: g_rd};

  for (genvar i = 0; i < NTAP; i++) begin : g_chain
    hsrk4_cell u_cell (
      .clk(clk), .shift(tap_shift), .tap_i(taps[i]),
      .tap_o(taps[i+1]), .val(vals[i])
    );
  end

  // stencil, stage update and final update arithmetic
  always_comb begin
    acc     = 52'(px) + 52'(py) + 52'sd32768;
    d1      = 33'(d) + 33'sd1;
    half    = d1[32:1];
    a_val   = (stage == 2'd2) ? sat32(40'(u) + 40'(d)) : sat32(40'(u) + 40'(half));
    s_base  = (stage == 2'd0) ? '0 : s;
    s_inc   = (stage == 2'd1 || stage == 2'd2) ? (40'(d) <<< 1) : 40'(d);
    s_new   = s_base + s_inc;
    x3      = s_new + 40'sd3;
    y3      = x3 >>> 1;
    m40     = y3 + 40'sd6442450944;
    // constant multiplies of the divide by three
    qh_prod = 33'(dvd[DIV_W-1:17]) * HI_MUL;
    rprod   = 38'(rsum) * LO_MUL;
    q       = $signed({1'b0, dvd}) - 35'sd2147483648;
    t_new   = sat32(40'(u) + 40'(q));
  end

  assign a_we = (state == ST_SWEEP) && (phase == 4'd9) && (stage == 2'd0 || stage == 2'd2);
  assign b_we = (state == ST_SWEEP) && (phase == 4'd9) && (stage == 2'd1);
  assign s_we = (state == ST_SWEEP) && (phase == 4'd9) && (stage != 2'd3);

  always_comb begin
    t_we    = 1'b0;
    t_waddr = k_addr;
    t_wdata = t_new;
    if (state == ST_DWR) begin
      t_we = 1'b1;
    end else if (accept && req.cmd == CMD_WRITE && in_rng) begin
      t_we    = 1'b1;
      t_waddr = {req.row, req.col};
      t_wdata = req.value;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    tap_border <= rd_border;
    if (state == ST_SWEEP) begin
      case (phase)
        4'd5: begin
          u <= t_rd;
          s <= $signed(s_rd);
        end
        4'd6: begin
          sx <= 34'(vals[4]) + 34'(vals[3]) - (34'(vals[0]) <<< 1);
          sy <= 34'(vals[2]) + 34'(vals[1]) - (34'(vals[0]) <<< 1);
        end
        4'd7: begin
          px <= $signed({1'b0, gain_x}) * sx;
          py <= $signed({1'b0, gain_y}) * sy;
        end
        4'd8: begin
          d <= sat32(40'($signed(acc[51:FRAC_BITS])));
        end
        4'd9: begin
          dvd <= m40[DIV_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (state == ST_DIV) begin
      if (!dcnt) begin
        qh   <= DIV_W'(qh_prod);
        rsum <= {1'b0, dvd[DIV_W-1:17], 1'b0} + 19'(dvd[16:0]);
      end else begin
        dvd <= qh + DIV_W'(rprod[37:20]);
      end
    end
    if (state == ST_RD) begin
      res_value <= rd_ok ? t_rd : '0;
    end
    if (accept) begin
      res_value <= '0;
      rd_ok     <= in_rng;
      case (req.cmd)
        CMD_WRITE:   res_status <= !in_rng;
        CMD_READ:    res_status <= !in_rng;
        CMD_ADVANCE: res_status <= 1'b0;
        default:     res_status <= 1'b1;
      endcase
    end
    if (state == ST_FIN && (!out_valid || rsp.ready)) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rows_in_use <= 8'd100;
      cols_in_use <= 8'd100;
      gain_x      <= 16'd6554;
      gain_y      <= 16'd6554;
      stage       <= 2'd0;
      r           <= ROW_W'(1);
      c           <= COL_W'(1);
      phase       <= 4'd0;
      dcnt        <= 1'b0;
      out_valid   <= 1'b0;
      tap_shift   <= 1'b0;
    end else begin
      tap_shift <= rd_shift;
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS:   rows_in_use <= cfg_data[7:0];
          REG_COLS:   cols_in_use <= cfg_data[7:0];
          REG_GAIN_X: gain_x      <= cfg_data;
          REG_GAIN_Y: gain_y      <= cfg_data;
          default:    gain_y      <= gain_y;
        endcase
      end
      if (rsp.valid && rsp.ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            stage <= 2'd0;
            r     <= ROW_W'(1);
            c     <= COL_W'(1);
            phase <= 4'd0;
            case (req.cmd)
              CMD_READ:    state <= ST_RD;
              CMD_ADVANCE: state <= (nr >= 8'd3 && nc >= 8'd3) ? ST_SWEEP : ST_FIN;
              default:     state <= ST_FIN;
            endcase
          end
        end
        ST_RD: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else if (rsp.valid && rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_SWEEP: begin
          if (phase == 4'd9) begin
            phase <= 4'd0;
            if (stage == 2'd3) begin
              dcnt  <= 1'b0;
              state <= ST_DIV;
            end else if (last_col) begin
              c <= COL_W'(1);
              if (last_row) begin
                r     <= ROW_W'(1);
                stage <= stage + 2'd1;
              end else begin
                r <= r + ROW_W'(1);
              end
            end else begin
              c <= c + COL_W'(1);
            end
          end else begin
            phase <= phase + 4'd1;
          end
        end
        ST_DIV: begin
          dcnt <= 1'b1;
          if (dcnt) begin
            state <= ST_DWR;
          end
        end
        ST_DWR: begin
          if (last_col) begin
            c <= COL_W'(1);
            if (last_row) begin
              r     <= ROW_W'(1);
              state <= ST_FIN;
            end else begin
              r     <= r + ROW_W'(1);
              state <= ST_SWEEP;
            end
          end else begin
            c     <= c + COL_W'(1);
            state <= ST_SWEEP;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `HSRK4_ASSERT_IMP(a_div_last_stage, state == ST_DIV || state == ST_DWR, stage == 2'd3)
  `HSRK4_ASSERT_IMP(a_t_write_src, t_we && state != ST_IDLE, state == ST_DWR)
  `HSRK4_ASSERT_NXT(a_accept_leaves_idle, accept, state != ST_IDLE)
  `HSRK4_ASSERT_IMP(a_sweep_interior, state == ST_SWEEP, r != '0 && c != '0)

endmodule

[sv/hsrk4_ram.sv]
// ----------------------------------------------------------------------------
// hsrk4_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module hsrk4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/hsrk4_cell.sv]
// ----------------------------------------------------------------------------
// hsrk4_cell
// one tap of the stencil window chain: holds a fetched neighbour and
// picks the border copy or the stage grid copy
// ----------------------------------------------------------------------------
module hsrk4_cell (
  input  logic              clk,
  input  logic              shift,
  input  hsrk4_pkg::tap_t   tap_i,
  output hsrk4_pkg::tap_t   tap_o,
  output hsrk4_pkg::temp_t  val
);
  import hsrk4_pkg::*;

  tap_t tap_q;

  always_ff @(posedge clk) begin
    if (shift) begin
      tap_q <= tap_i;
    end
  end

  assign tap_o = tap_q;
  assign val   = tap_q.border ? tap_q.t_data : tap_q.g_data;

endmodule
